// File: rtl/core/pcnl_pkg.sv
// Shared types and constants of the pair cutoff neighbor list core.
// No dependencies; the front end, queue, back end and top level import it.
`timescale 1ns / 1ps

package pcnl_pkg;

  // Field widths fixed by the item format
  localparam int unsigned SLOT_W    = 11;
  localparam int unsigned COORD_W   = 20;
  localparam int unsigned CUT_W     = 44;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 44;
  localparam int unsigned STYLE_W   = 2;

  // Distance datapath widths
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * COORD_W;
  localparam int unsigned SUM_W  = SQ_W + 2;

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Commands
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Pair list styles
  localparam logic [STYLE_W-1:0] STYLE_MATCHED = 2'd0;
  localparam logic [STYLE_W-1:0] STYLE_CROSS   = 2'd1;
  localparam logic [STYLE_W-1:0] STYLE_ALL     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_STYLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ    = 2'd3;

  // Operation carried by a queue entry
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PAIR = 1'b1
  } op_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [SLOT_W-1:0]         atom_slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } pcnl_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] first_atom;
    logic [SLOT_W-1:0] second_atom;
    logic              within_cutoff;
    logic              pair_valid;
    logic              last_pair;
  } pcnl_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pcnl_pos_t;

  typedef struct packed {
    logic [SLOT_W-1:0] first_atom;
    logic [SLOT_W-1:0] second_atom;
    logic              pair_valid;
    logic              last_pair;
  } pcnl_pair_t;

  // For a load, pair.first_atom holds the target slot
  typedef struct packed {
    op_e        op;
    pcnl_pair_t pair;
    pcnl_pos_t  pos;
  } pcnl_entry_t;

endpackage

// File: rtl/core/pcnl_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module pcnl_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: rtl/core/pcnl_front.sv
// Front end: accepts items, decodes the command and runs the pair enumerator.
// Depends on pcnl_pkg; feeds loads and pairs into pcnl_queue.
`timescale 1ns / 1ps

module pcnl_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pcnl_pkg::pcnl_in_t   in_data_i,
  input  logic [1:0]           list_style_i,
  input  logic [10:0]          first_count_i,
  input  logic [10:0]          second_count_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output pcnl_pkg::pcnl_entry_t push_entry_o
);
  import pcnl_pkg::*;

  logic [SLOT_W-1:0] row_q, row_d, col_q, col_d;
  logic              done_q, done_d;
  logic              accept;

  // Enumerator scratch
  logic [SLOT_W:0]   r1, c1, ca, ca1, fc_x, sc_x, r_x, c_x;
  logic              pv, last;
  logic [SLOT_W-1:0] pa, pb, row_n, col_n;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign r_x  = {1'b0, row_q};
  assign c_x  = {1'b0, col_q};
  assign fc_x = {1'b0, first_count_i};
  assign sc_x = {1'b0, second_count_i};
  assign r1   = r_x + 12'd1;
  assign c1   = c_x + 12'd1;
  assign ca   = (c_x <= r_x) ? r1 : c_x;
  assign ca1  = ca + 12'd1;

  // Next pair of the selected style
  always_comb begin
    pv    = 1'b0;
    last  = 1'b0;
    pa    = '0;
    pb    = '0;
    row_n = row_q;
    col_n = col_q;
    if (!done_q) begin
      case (list_style_i)
        STYLE_MATCHED: begin
          if (r_x < fc_x) begin
            pv    = 1'b1;
            pa    = row_q;
            pb    = row_q + first_count_i;
            last  = (r1 == fc_x);
            row_n = r1[SLOT_W-1:0];
          end
        end
        STYLE_CROSS: begin
          if (r_x < fc_x && c_x < sc_x) begin
            pv   = 1'b1;
            pa   = row_q;
            pb   = col_q + first_count_i;
            last = (r1 == fc_x) && (c1 == sc_x);
            if (c1 >= sc_x) begin
              col_n = '0;
              row_n = r1[SLOT_W-1:0];
            end else begin
              col_n = c1[SLOT_W-1:0];
            end
          end
        end
        STYLE_ALL: begin
          if (ca < fc_x) begin
            pv   = 1'b1;
            pa   = row_q;
            pb   = ca[SLOT_W-1:0];
            last = ((r_x + 12'd2) == fc_x) && (ca1 == fc_x);
            if (ca1 >= fc_x) begin
              col_n = '0;
              row_n = r1[SLOT_W-1:0];
            end else begin
              col_n = ca1[SLOT_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Command decode
  always_comb begin
    row_d        = row_q;
    col_d        = col_q;
    done_d       = done_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    push_entry_o.pos.x = in_data_i.pos_x;
    push_entry_o.pos.y = in_data_i.pos_y;
    push_entry_o.pos.z = in_data_i.pos_z;
    if (accept) begin
      unique case (in_data_i.cmd)
        CMD_LOAD: begin
          push_o                        = 1'b1;
          push_entry_o.op               = OP_LOAD;
          push_entry_o.pair.first_atom  = in_data_i.atom_slot;
        end
        CMD_RESTART: begin
          row_d  = '0;
          col_d  = '0;
          done_d = 1'b0;
        end
        CMD_ADVANCE: begin
          push_o                        = 1'b1;
          push_entry_o.op               = OP_PAIR;
          push_entry_o.pair.first_atom  = pa;
          push_entry_o.pair.second_atom = pb;
          push_entry_o.pair.pair_valid  = pv;
          push_entry_o.pair.last_pair   = pv && last;
          row_d  = row_n;
          col_d  = col_n;
          done_d = done_q || !pv || last;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      done_q <= 1'b0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      done_q <= done_d;
    end
  end

endmodule

// File: rtl/core/pcnl_queue.sv
// Short FIFO between the front end and the distance back end.
// Depends on pcnl_pkg for the entry type and depth.
`timescale 1ns / 1ps

module pcnl_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pcnl_pkg::pcnl_entry_t push_entry_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  nonempty_o,
  output pcnl_pkg::pcnl_entry_t head_o
);
  import pcnl_pkg::*;

  pcnl_entry_t        slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = slot_q[rptr_q];
  assign do_pop     = pop_i && nonempty_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/pcnl_back.sv
// Back end: position store access, squared distance pipeline, output register.
// Depends on pcnl_pkg and pcnl_ram.
`timescale 1ns / 1ps

module pcnl_back #(
  parameter int unsigned ATOM_SLOTS = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [43:0]           cutoff_sq_i,
  input  logic                  q_nonempty_i,
  input  pcnl_pkg::pcnl_entry_t q_head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pcnl_pkg::pcnl_out_t   out_data_o
);
  import pcnl_pkg::*;

  localparam int unsigned AW    = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
  localparam int unsigned POS_W = $bits(pcnl_pos_t);

  logic                   adv;
  logic [SLOT_W+AW-1:0]   ext_a, ext_b;
  logic [AW-1:0]          addr_a, addr_b;
  logic                   oob_a, oob_b;
  logic [POS_W-1:0]       rd_a, rd_b;
  pcnl_pos_t              pos_a, pos_b;

  // Stage registers
  logic                   v1_q, v2_q, v3_q, out_valid_q;
  pcnl_pair_t             p1_q, p2_q, p3_q;
  logic                   oob_a1_q, oob_b1_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SQ_W-1:0]        sx_q, sy_q, sz_q;
  logic [SUM_W-1:0]       sum;
  pcnl_out_t              out_q, out_d;

  // The whole pipeline moves together unless the output is held
  assign adv         = !out_valid_q || out_ready_i;
  assign pop_o       = adv && q_nonempty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Slot to store address; slots past the store read as the origin
  assign ext_a  = {{AW{1'b0}}, q_head_i.pair.first_atom};
  assign ext_b  = {{AW{1'b0}}, q_head_i.pair.second_atom};
  assign addr_a = ext_a[AW-1:0];
  assign addr_b = ext_b[AW-1:0];
  assign oob_a  = 32'(q_head_i.pair.first_atom) >= 32'(ATOM_SLOTS);
  assign oob_b  = 32'(q_head_i.pair.second_atom) >= 32'(ATOM_SLOTS);

  pcnl_ram #(
    .WIDTH (POS_W),
    .DEPTH (ATOM_SLOTS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (pop_o && q_head_i.op == OP_LOAD && !oob_a),
    .waddr_i   (addr_a),
    .wdata_i   (q_head_i.pos),
    .re_i      (pop_o),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Stage 2: coordinate differences
  assign pos_a = pcnl_pos_t'(rd_a);
  assign pos_b = pcnl_pos_t'(rd_b);
  assign ax = oob_a1_q ? '0 : pos_a.x;
  assign ay = oob_a1_q ? '0 : pos_a.y;
  assign az = oob_a1_q ? '0 : pos_a.z;
  assign bx = oob_b1_q ? '0 : pos_b.x;
  assign by = oob_b1_q ? '0 : pos_b.y;
  assign bz = oob_b1_q ? '0 : pos_b.z;
  assign dx_d = DIFF_W'(ax) - DIFF_W'(bx);
  assign dy_d = DIFF_W'(ay) - DIFF_W'(by);
  assign dz_d = DIFF_W'(az) - DIFF_W'(bz);

  // Stage 3: squares, each below 2^SQ_W
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;

  // Stage 4: sum and cutoff compare
  assign sum = SUM_W'(sx_q) + SUM_W'(sy_q) + SUM_W'(sz_q);

  always_comb begin
    out_d               = '0;
    out_d.first_atom    = p3_q.first_atom;
    out_d.second_atom   = p3_q.second_atom;
    out_d.pair_valid    = p3_q.pair_valid;
    out_d.last_pair     = p3_q.last_pair;
    out_d.within_cutoff = p3_q.pair_valid && (CUT_W'(sum) <= cutoff_sq_i);
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q     <= q_head_i.pair;
      oob_a1_q <= oob_a;
      oob_b1_q <= oob_b;
      p2_q     <= p1_q;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      dz_q     <= dz_d;
      p3_q     <= p2_q;
      sx_q     <= px[SQ_W-1:0];
      sy_q     <= py[SQ_W-1:0];
      sz_q     <= pz[SQ_W-1:0];
      out_q    <= out_d;
    end
  end

  // Stage valid bits; loads leave the pipeline after the store write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= pop_o && q_head_i.op == OP_PAIR;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

endmodule

// File: rtl/core/pair_cutoff_neighbor_list_core.sv
// Top level of the pair cutoff neighbor list core: configuration registers
// and the front end, queue and back end. Depends on pcnl_pkg and submodules.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i/in_ready_o, in_data_i) takes commands: load a
//   position into a store slot, restart the pair enumeration, or advance one
//   pair. Only an advance produces an item on the output channel
//   (out_valid_o/out_ready_i, out_data_o): the pair's slots, a within-cutoff
//   flag, a pair-valid flag and a last-pair flag, in command order.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes list
//   style, a group size or the squared cutoff, one per write; write it only
//   while no advance is in flight.
//   Throughput: one item per cycle while out_ready_i is high, set by the
//   dual-read position store that fetches both atoms of a pair at once.
//   Path: an advance passes through the queue, store read, difference stage,
//   square stage, then sum/compare into the output register.
//   Reset clears the enumerator, queue and pipeline; configuration returns to
//   all-pairs style with zero counts and cutoff. The store is not cleared and
//   needs no clearing pass: a slot must be loaded before a pair reads it.
//   When the receiver stalls, the pipeline holds; the queue absorbs up to two
//   further loads or advances before in_ready_o drops.
module pair_cutoff_neighbor_list_core #(
  parameter int unsigned ATOM_SLOTS = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcnl_pkg::pcnl_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcnl_pkg::pcnl_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [43:0]         cfg_wdata_i
);
  import pcnl_pkg::*;

  logic [STYLE_W-1:0] list_style_q;
  logic [SLOT_W-1:0]  first_count_q, second_count_q;
  logic [CUT_W-1:0]   cutoff_sq_q;

  logic               q_full, q_nonempty, push, pop;
  pcnl_entry_t        push_entry, q_head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_style_q   <= STYLE_ALL;
      first_count_q  <= '0;
      second_count_q <= '0;
      cutoff_sq_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LIST_STYLE:   list_style_q   <= cfg_wdata_i[STYLE_W-1:0];
        CFG_FIRST_COUNT:  first_count_q  <= cfg_wdata_i[SLOT_W-1:0];
        CFG_SECOND_COUNT: second_count_q <= cfg_wdata_i[SLOT_W-1:0];
        CFG_CUTOFF_SQ:    cutoff_sq_q    <= cfg_wdata_i[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  pcnl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .list_style_i   (list_style_q),
    .first_count_i  (first_count_q),
    .second_count_i (second_count_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  pcnl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .nonempty_o   (q_nonempty),
    .head_o       (q_head)
  );

  pcnl_back #(
    .ATOM_SLOTS (ATOM_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cutoff_sq_i  (cutoff_sq_q),
    .q_nonempty_i (q_nonempty),
    .q_head_i     (q_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for pair_cutoff_neighbor_list_core: predicts each pair,
// its cutoff flag and its last-pair flag. Depends on pcnl_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import pcnl_pkg::*;

  localparam int unsigned ATOM_SLOTS   = 2048;
  localparam int unsigned SLOT_MASK    = (1 << SLOT_W) - 1;
  localparam longint unsigned CUT_MAX  = (64'd1 << CUT_W) - 1;
  localparam logic [STYLE_W-1:0] STYLE_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET  = 1750;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint unsigned RUN_LIMIT_NS = 5_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  pcnl_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pcnl_out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  pair_cutoff_neighbor_list_core #(.ATOM_SLOTS(ATOM_SLOTS)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the position store and the enumerator
  logic signed [COORD_W-1:0] store_x [ATOM_SLOTS];
  logic signed [COORD_W-1:0] store_y [ATOM_SLOTS];
  logic signed [COORD_W-1:0] store_z [ATOM_SLOTS];
  bit loaded [ATOM_SLOTS];
  logic [STYLE_W-1:0] style_r = STYLE_ALL;
  int unsigned first_cnt = 0;
  int unsigned second_cnt = 0;
  longint unsigned cutoff_r = 0;
  int unsigned enum_row = 0;
  int unsigned enum_col = 0;
  bit enum_done = 1'b0;

  pcnl_out_t pending_pairs[$];

  // Run statistics
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned phases_run = 0;
  int unsigned results_seen = 0;
  int unsigned valid_seen = 0;
  int unsigned within_seen = 0;
  int unsigned last_seen = 0;

  bit spread_full = 1'b1;
  int unsigned send_burst_left = 0;
  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;

  // Next pair of the current style; state moves only when commit is set
  function automatic void next_pair(input bit commit, output bit ok,
                                    output int unsigned a, output int unsigned b,
                                    output bit last);
    int unsigned r;
    int unsigned c;
    ok = 1'b0;
    a = 0;
    b = 0;
    last = 1'b0;
    r = enum_row;
    c = enum_col;
    if (!enum_done) begin
      case (style_r)
        STYLE_MATCHED: begin
          if (r < first_cnt) begin
            ok = 1'b1;
            a = r;
            b = (r + first_cnt) & SLOT_MASK;
            last = (r + 1 == first_cnt);
            r = (r + 1) & SLOT_MASK;
          end
        end
        STYLE_CROSS: begin
          if (r < first_cnt && c < second_cnt) begin
            ok = 1'b1;
            a = r;
            b = (c + first_cnt) & SLOT_MASK;
            last = (r + 1 == first_cnt) && (c + 1 == second_cnt);
            c++;
            if (c >= second_cnt) begin
              c = 0;
              r++;
            end
            r &= SLOT_MASK;
            c &= SLOT_MASK;
          end
        end
        STYLE_ALL: begin
          if (c <= r) c = r + 1;
          if (c < first_cnt) begin
            ok = 1'b1;
            a = r;
            b = c;
            last = (r + 2 == first_cnt) && (c + 1 == first_cnt);
            c++;
            if (c >= first_cnt) begin
              c = 0;
              r++;
            end
            r &= SLOT_MASK;
            c &= SLOT_MASK;
          end
        end
        default: ;
      endcase
    end
    if (commit) begin
      if (ok) begin
        enum_row = r;
        enum_col = c;
      end
      if (!ok || last) enum_done = 1'b1;
    end
  endfunction

  function automatic longint unsigned pair_dist_sq(int unsigned a, int unsigned b);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(store_x[a]) - longint'(store_x[b]);
    dy = longint'(store_y[a]) - longint'(store_y[b]);
    dz = longint'(store_z[a]) - longint'(store_z[b]);
    return $unsigned(dx * dx + dy * dy + dz * dz);
  endfunction

  // Update the shadow state for one accepted item; advances queue a result
  function automatic void apply_command(pcnl_in_t it);
    bit ok;
    bit last;
    int unsigned a;
    int unsigned b;
    pcnl_out_t res;
    case (cmd_e'(it.cmd))
      CMD_LOAD: begin
        store_x[it.atom_slot] = it.pos_x;
        store_y[it.atom_slot] = it.pos_y;
        store_z[it.atom_slot] = it.pos_z;
        loaded[it.atom_slot] = 1'b1;
      end
      CMD_RESTART: begin
        enum_row = 0;
        enum_col = 0;
        enum_done = 1'b0;
      end
      CMD_ADVANCE: begin
        next_pair(1'b1, ok, a, b, last);
        res = '0;
        if (ok) begin
          res.first_atom = a[SLOT_W-1:0];
          res.second_atom = b[SLOT_W-1:0];
          res.within_cutoff = (pair_dist_sq(a, b) <= cutoff_r);
          res.pair_valid = 1'b1;
          res.last_pair = last;
        end
        pending_pairs = {pending_pairs, res};
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (spread_full) begin
      if (pick == 0) return {1'b0, {(COORD_W-1){1'b1}}};
      if (pick == 1) return {1'b1, {(COORD_W-1){1'b0}}};
      return COORD_W'($urandom);
    end
    return COORD_W'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic pcnl_in_t cmd_item(cmd_e c);
    pcnl_in_t it;
    it.cmd = c;
    it.atom_slot = SLOT_W'($urandom);
    it.pos_x = COORD_W'($urandom);
    it.pos_y = COORD_W'($urandom);
    it.pos_z = COORD_W'($urandom);
    return it;
  endfunction

  function automatic pcnl_in_t load_at(int unsigned slot, logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y,
                                      logic signed [COORD_W-1:0] z);
    pcnl_in_t it;
    it.cmd = CMD_LOAD;
    it.atom_slot = SLOT_W'(slot);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    return it;
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count < MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_count++;
  endfunction

  // Send one item; valid stays high after acceptance until the next call or a hold
  task automatic send_item(input pcnl_in_t it);
    int unsigned gap;
    if (send_burst_left == 0) begin
      send_burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    send_burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    apply_command(it);
    if (cmd_e'(it.cmd) != CMD_NONE) items_sent++;
    if (cmd_e'(it.cmd) == CMD_LOAD) loads_sent++;
  endtask

  // Loads any slot the coming pair reads that was never written, then advances
  task automatic send_advance();
    bit ok;
    bit last;
    int unsigned a;
    int unsigned b;
    next_pair(1'b0, ok, a, b, last);
    if (ok && !loaded[a]) send_item(load_at(a, rand_coord(), rand_coord(), rand_coord()));
    if (ok && !loaded[b]) send_item(load_at(b, rand_coord(), rand_coord(), rand_coord()));
    send_item(cmd_item(CMD_ADVANCE));
  endtask

  // Hold the sender until every queued result has come back and the pipe is empty
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LIST_STYLE:   style_r = data[STYLE_W-1:0];
      CFG_FIRST_COUNT:  first_cnt = data[SLOT_W-1:0];
      CFG_SECOND_COUNT: second_cnt = data[SLOT_W-1:0];
      CFG_CUTOFF_SQ:    cutoff_r = data[CUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(logic [STYLE_W-1:0] style, int unsigned fc, int unsigned sc,
                            longint unsigned cut);
    write_reg(CFG_LIST_STYLE, CFG_DAT_W'(style));
    write_reg(CFG_FIRST_COUNT, CFG_DAT_W'(fc));
    write_reg(CFG_SECOND_COUNT, CFG_DAT_W'(sc));
    write_reg(CFG_CUTOFF_SQ, CFG_DAT_W'(cut));
    cfg_we_i <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    pcnl_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_data_o.pair_valid) valid_seen++;
      if (out_data_o.within_cutoff) within_seen++;
      if (out_data_o.last_pair) last_seen++;
      if (pending_pairs.size() == 0) begin
        note_failure($sformatf("unexpected result %p", out_data_o));
      end else begin
        want = pending_pairs.pop_front();
        if (out_data_o.first_atom !== want.first_atom ||
            out_data_o.second_atom !== want.second_atom ||
            out_data_o.within_cutoff !== want.within_cutoff ||
            out_data_o.pair_valid !== want.pair_valid ||
            out_data_o.last_pair !== want.last_pair)
          note_failure($sformatf("expected %p got %p", want, out_data_o));
      end
    end
  end

  // Receiver back-pressure: modes from always ready to long stalls
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 300);
    end
    ready_left--;
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 9) < 7);
      2: out_ready_i <= ($urandom_range(0, 9) < 3);
      default: out_ready_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Reset defaults, then an advance with no pairs and an ignored command
  task automatic test_idle_defaults();
    send_advance();
    send_item(cmd_item(CMD_NONE));
    drain_pipeline();
  endtask

  // Extreme coordinates through all-pairs, cross and the unused style
  task automatic test_small_styles();
    send_item(load_at(0, {1'b0, {(COORD_W-1){1'b1}}}, {1'b0, {(COORD_W-1){1'b1}}},
                      {1'b0, {(COORD_W-1){1'b1}}}));
    send_item(load_at(1, {1'b1, {(COORD_W-1){1'b0}}}, {1'b1, {(COORD_W-1){1'b0}}},
                      {1'b1, {(COORD_W-1){1'b0}}}));
    send_item(load_at(2, '0, '0, '0));
    drain_pipeline();
    write_regs(STYLE_ALL, 3, 0, CUT_MAX);
    send_item(cmd_item(CMD_RESTART));
    repeat (4) send_advance();
    drain_pipeline();
    write_regs(STYLE_CROSS, 1, 2, 0);
    send_item(cmd_item(CMD_RESTART));
    repeat (3) send_advance();
    drain_pipeline();
    write_regs(STYLE_UNUSED, 3, 3, CUT_MAX);
    send_item(cmd_item(CMD_RESTART));
    send_advance();
    drain_pipeline();
  endtask

  // Distance exactly at the cutoff, one below it, and a zero cutoff
  task automatic test_cutoff_boundary();
    longint unsigned d;
    d = pair_dist_sq(0, 1);
    write_regs(STYLE_MATCHED, 1, 0, d);
    send_item(cmd_item(CMD_RESTART));
    send_advance();
    drain_pipeline();
    write_regs(STYLE_MATCHED, 1, 0, d - 1);
    send_item(cmd_item(CMD_RESTART));
    send_advance();
    send_item(load_at(1, store_x[0], store_y[0], store_z[0]));
    drain_pipeline();
    write_regs(STYLE_MATCHED, 1, 0, 0);
    send_item(cmd_item(CMD_RESTART));
    send_advance();
    drain_pipeline();
  endtask

  // Shrinking the group mid-enumeration leaves the counters out of range
  task automatic test_register_changes();
    write_regs(STYLE_ALL, 3, 0, CUT_MAX);
    send_item(cmd_item(CMD_RESTART));
    repeat (2) send_advance();
    drain_pipeline();
    write_regs(STYLE_ALL, 2, 0, CUT_MAX);
    send_advance();
    drain_pipeline();
  endtask

  // Full-size groups and an empty one
  task automatic test_extreme_counts();
    write_regs(STYLE_CROSS, 1024, 1024, CUT_MAX >> 3);
    send_item(cmd_item(CMD_RESTART));
    repeat (2) send_advance();
    drain_pipeline();
    write_regs(STYLE_MATCHED, 0, 1024, CUT_MAX);
    send_item(cmd_item(CMD_RESTART));
    send_advance();
    drain_pipeline();
  endtask

  function automatic int unsigned rand_count();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 1024;
    if (pick == 1) return $urandom_range(0, 1024);
    return $urandom_range(0, 10);
  endfunction

  // One random phase: new settings, mostly clean enumerations with some noise
  task automatic run_phase();
    logic [STYLE_W-1:0] style;
    int unsigned fc;
    int unsigned sc;
    int unsigned pick;
    int unsigned n_adv;
    longint unsigned total;
    longint unsigned cut;
    drain_pipeline();
    phases_run++;
    pick = $urandom_range(0, 99);
    if (pick < 4) style = STYLE_UNUSED;
    else if (pick < 36) style = STYLE_MATCHED;
    else if (pick < 68) style = STYLE_CROSS;
    else style = STYLE_ALL;
    fc = rand_count();
    sc = rand_count();
    spread_full = $urandom_range(0, 1);
    pick = $urandom_range(0, 19);
    if (pick == 0) cut = 0;
    else if (pick == 1) cut = CUT_MAX;
    else if (spread_full) cut = ({$urandom, $urandom} & CUT_MAX) >> $urandom_range(2, 6);
    else cut = $urandom_range(0, 1 << 26);
    write_regs(style, fc, sc, cut);
    case (style)
      STYLE_MATCHED: total = fc;
      STYLE_CROSS:   total = longint'(fc) * sc;
      STYLE_ALL:     total = (fc > 1) ? longint'(fc) * (fc - 1) / 2 : 0;
      default:       total = 0;
    endcase
    n_adv = ((total > 48) ? 48 : int'(total)) + $urandom_range(0, 2);
    // now and then carry on from the old counters
    if ($urandom_range(0, 6) != 0) send_item(cmd_item(CMD_RESTART));
    repeat (n_adv) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)
        send_item(load_at($urandom_range(0, ATOM_SLOTS - 1), rand_coord(), rand_coord(),
                          rand_coord()));
      else if (pick < 14) send_item(cmd_item(CMD_NONE));
      else if (pick < 16) send_item(cmd_item(CMD_RESTART));
      send_advance();
    end
  endtask

  task automatic test_random_phases();
    while (items_sent < ITEM_TARGET) run_phase();
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_LIST_STYLE;
    cfg_wdata_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_defaults();
    test_small_styles();
    test_cutoff_boundary();
    test_register_changes();
    test_extreme_counts();
    test_random_phases();
    drain_pipeline();

    $display("Covered %0d commands (%0d loads) over %0d random setting phases.",
             items_sent, loads_sent, phases_run);
    $display("Checked %0d results: %0d pairs, %0d within cutoff, %0d enumeration ends.",
             results_seen, valid_seen, within_seen, last_seen);
    if (fail_count == 0) begin
      $display("pair_cutoff_neighbor_list_core regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("pair_cutoff_neighbor_list_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("pair_cutoff_neighbor_list_core regression: fail");
    $finish;
  end

endmodule
